[rtl/pst_pkg.sv]
package pst_pkg;

  localparam int DEF_ENTRIES = 48;
  localparam int DEF_CORES   = 4;

  localparam int ADDR_W = 64;
  localparam int CORE_W = 2;
  localparam int DIST_W = 8;
  localparam int SHIFT_W = 5;
  localparam int CONF_W = 2;
  // Rank field width; it covers the largest table of 64 entries.
  localparam int RANK_W = 6;
  localparam int RANK_SPAN = 2 ** RANK_W;

  localparam logic [CONF_W-1:0] CONF_MAX = 2'd3;
  localparam logic [CONF_W-1:0] CONF_TRIG = 2'd2;
  localparam logic [CONF_W-1:0] CONF_NEW = 2'd1;

  localparam logic [DIST_W-1:0] NEAR_RST = 8'd8;
  localparam logic [DIST_W-1:0] FAR_RST = 8'd32;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;

  typedef enum logic [1:0] {
    REG_NEAR  = 2'd0,
    REG_FAR   = 2'd1,
    REG_SHIFT = 2'd2
  } cfg_reg_t;

  // Entry view that a cell shows for the core under lookup.
  typedef struct packed {
    logic              pc_eq;
    logic [CONF_W-1:0] conf;
    logic [RANK_W-1:0] rank;
    logic [ADDR_W-1:0] last;
    logic [ADDR_W-1:0] stride;
  } pst_status_t;

  // Update command broadcast to all cells.
  typedef struct packed {
    logic              rank_en;
    logic [RANK_W-1:0] old_rank;
    logic              wr_pc;
    logic              wr_last;
    logic              wr_conf;
    logic              wr_stride;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] stride;
    logic [CONF_W-1:0] conf;
  } pst_cmd_t;

endpackage

[rtl/pst_cell.sv]
module pst_cell #(
  parameter int ENTRIES = pst_pkg::DEF_ENTRIES,
  parameter int CORES   = pst_pkg::DEF_CORES,
  parameter int IDX     = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [pst_pkg::CORE_W-1:0]          core,
  input  logic [pst_pkg::ADDR_W-1:0]          look_pc,
  input  logic                                sel,
  input  logic                                upd,
  input  pst_pkg::pst_cmd_t                   cmd,
  input  logic [pst_pkg::RANK_SPAN-1:0]       mask_in,
  output logic [pst_pkg::RANK_SPAN-1:0]       mask_out,
  output pst_pkg::pst_status_t                status
);

  localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;

  logic [pst_pkg::ADDR_W-1:0] pc_r     [CORES];
  logic [pst_pkg::ADDR_W-1:0] last_r   [CORES];
  logic [pst_pkg::ADDR_W-1:0] stride_r [CORES];
  logic [pst_pkg::CONF_W-1:0] conf_r   [CORES];
  logic [pst_pkg::RANK_W-1:0] rank_r   [CORES];
  logic [CW-1:0]              slot;
  logic [pst_pkg::RANK_SPAN-1:0] own_mask;

  assign slot = CW'(core);

  always_comb begin
    status.pc_eq  = (pc_r[slot] == look_pc);
    status.conf   = conf_r[slot];
    status.rank   = rank_r[slot];
    status.last   = last_r[slot];
    status.stride = stride_r[slot];
  end

  // Low-confidence entries mark their rank; the mask accumulates down the row.
  always_comb begin
    own_mask = '0;
    if (conf_r[slot] < pst_pkg::CONF_TRIG) begin
      own_mask[rank_r[slot]] = 1'b1;
    end
  end
  assign mask_out = mask_in | own_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CORES; c++) begin
        pc_r[c]     <= '0;
        last_r[c]   <= '0;
        stride_r[c] <= '0;
        conf_r[c]   <= '0;
        rank_r[c]   <= pst_pkg::RANK_W'(IDX);
      end
    end else if (upd) begin
      if (cmd.rank_en) begin
        if (sel) begin
          rank_r[slot] <= pst_pkg::RANK_W'(ENTRIES - 1);
        end else if (rank_r[slot] > cmd.old_rank) begin
          rank_r[slot] <= rank_r[slot] - 1'b1;
        end
      end
      if (sel) begin
        if (cmd.wr_pc)     pc_r[slot]     <= cmd.pc;
        if (cmd.wr_last)   last_r[slot]   <= cmd.addr;
        if (cmd.wr_conf)   conf_r[slot]   <= cmd.conf;
        if (cmd.wr_stride) stride_r[slot] <= cmd.stride;
      end
    end
  end

endmodule

[rtl/pc_stride_prefetcher.sv]
// An accepted item passes through the lookup, select and update states; the update waits
// while an unread result is held. A new item is taken only in idle, as the table walk
// through the cell row and the multiply stage hold one item at a time.
// Reset: synchronous, active low; every entry is invalid with zero fields and rank
// equal to its index, and the distances and page shift take their reset values.
module pc_stride_prefetcher #(
  parameter int ENTRIES = pst_pkg::DEF_ENTRIES,
  parameter int CORES   = pst_pkg::DEF_CORES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pst_pkg::CORE_W-1:0]         in_core_id,
  input  logic [pst_pkg::ADDR_W-1:0]         in_access_addr,
  input  logic [pst_pkg::ADDR_W-1:0]         in_pc,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_near_valid,
  output logic [pst_pkg::ADDR_W-1:0]         out_near_addr,
  output logic                               out_far_valid,
  output logic [pst_pkg::ADDR_W-1:0]         out_far_addr,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [pst_pkg::DIST_W-1:0]         cfg_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int AW = pst_pkg::ADDR_W;

  // The item walks through four one-hot states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_CALC = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers. Writes are always accepted; index 3 is dropped.
  logic [pst_pkg::DIST_W-1:0]  near_r, far_r;
  logic [pst_pkg::SHIFT_W-1:0] shift_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r  <= pst_pkg::NEAR_RST;
      far_r   <= pst_pkg::FAR_RST;
      shift_r <= pst_pkg::SHIFT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pst_pkg::REG_NEAR:  near_r  <= cfg_data;
        pst_pkg::REG_FAR:   far_r   <= cfg_data;
        pst_pkg::REG_SHIFT: shift_r <= cfg_data[pst_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [pst_pkg::CORE_W-1:0] core_r;
  logic [AW-1:0]              addr_r, pc_r;
  logic                       core_ok;

  assign in_ready = (state_r == ST_IDLE);
  assign core_ok  = (32'(core_r) < CORES);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      core_r <= in_core_id;
      addr_r <= in_access_addr;
      pc_r   <= in_pc;
    end
  end

  // The row of cells. Each cell keeps one entry of every core and passes the
  // low-confidence rank mask on to its neighbor.
  pst_pkg::pst_status_t           st [ENTRIES];
  logic [pst_pkg::RANK_SPAN-1:0]  mask [ENTRIES+1];
  logic [ENTRIES-1:0]             sel;
  logic                           upd;
  pst_pkg::pst_cmd_t              cmd;
  logic [IW-1:0]                  vic_r;

  assign mask[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign sel[g] = (vic_r == IW'(g));
    pst_cell #(
      .ENTRIES (ENTRIES),
      .CORES   (CORES),
      .IDX     (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .core     (core_r),
      .look_pc  (pc_r),
      .sel      (sel[g]),
      .upd      (upd),
      .cmd      (cmd),
      .mask_in  (mask[g]),
      .mask_out (mask[g+1]),
      .status   (st[g])
    );
  end

  // Lookup: the highest valid entry with the same pc is the hit, the highest
  // entry with the same pc is the reuse candidate, and the lowest marked rank
  // is the least recent low-confidence entry.
  logic          hit_found, same_found, low_found;
  logic [IW-1:0] hit_idx, same_idx;
  logic [pst_pkg::RANK_W-1:0] low_rank;
  logic          hit_found_r, same_found_r, low_found_r;
  logic [IW-1:0] hit_idx_r, same_idx_r;
  logic [pst_pkg::RANK_W-1:0] low_rank_r;

  always_comb begin
    hit_found  = 1'b0;
    same_found = 1'b0;
    hit_idx    = '0;
    same_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (st[i].pc_eq) begin
        same_found = 1'b1;
        same_idx   = IW'(i);
        if (st[i].conf != '0) begin
          hit_found = 1'b1;
          hit_idx   = IW'(i);
        end
      end
    end
    low_found = |mask[ENTRIES];
    low_rank  = '0;
    for (int r = pst_pkg::RANK_SPAN - 1; r >= 0; r--) begin
      if (mask[ENTRIES][r]) begin
        low_rank = pst_pkg::RANK_W'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) begin
      hit_found_r  <= hit_found;
      same_found_r <= same_found;
      low_found_r  <= low_found;
      hit_idx_r    <= hit_idx;
      same_idx_r   <= same_idx;
      low_rank_r   <= low_rank;
    end
  end

  // Select: read the hit entry, form the new stride and both products, and
  // pick the victim on a miss.
  pst_pkg::pst_status_t hs;
  logic [AW-1:0]  ns;
  logic           trig;
  logic [pst_pkg::RANK_W-1:0] target;
  logic           rank_found;
  logic [IW-1:0]  rank_idx, vic;

  logic [AW-1:0]  ns_r, prod_near_r, prod_far_r, old_stride_r;
  logic [pst_pkg::CONF_W-1:0] conf_r;
  logic           trig_r;

  assign hs = st[hit_idx_r];
  assign ns = addr_r - hs.last;
  assign trig = (hs.conf >= pst_pkg::CONF_TRIG) && (hs.stride != '0) &&
                ((hs.stride == ns) || ((hs.conf == pst_pkg::CONF_MAX) && (ns != '0)));

  always_comb begin
    target     = low_found_r ? low_rank_r : '0;
    rank_found = 1'b0;
    rank_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (st[i].rank == target) begin
        rank_found = 1'b1;
        rank_idx   = IW'(i);
      end
    end
    if (hit_found_r) begin
      vic = hit_idx_r;
    end else if (same_found_r) begin
      vic = same_idx_r;
    end else if (rank_found) begin
      vic = rank_idx;
    end else begin
      vic = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      vic_r        <= vic;
      ns_r         <= ns;
      conf_r       <= hs.conf;
      old_stride_r <= hs.stride;
      trig_r       <= trig;
      prod_near_r  <= hs.stride * AW'(near_r);
      prod_far_r   <= hs.stride * AW'(far_r);
    end
  end

  // Update: write the chosen entry, age the ranks and load the result.
  logic          go;
  logic          eq;
  logic [pst_pkg::CONF_W-1:0] nc;
  logic [AW-1:0] pn, pf;
  logic          keep_n, keep_f;

  assign go  = (state_r == ST_UPD) && (!out_valid || out_ready);
  assign upd = go && core_ok;
  assign eq  = (ns_r == old_stride_r);

  always_comb begin
    if (eq) begin
      nc = (conf_r < pst_pkg::CONF_MAX) ? conf_r + 1'b1 : conf_r;
    end else begin
      nc = (conf_r != '0) ? conf_r - 1'b1 : conf_r;
    end
    cmd.rank_en   = 1'b1;
    cmd.old_rank  = st[vic_r].rank;
    cmd.pc        = pc_r;
    cmd.addr      = addr_r;
    cmd.stride    = ns_r;
    if (hit_found_r) begin
      cmd.wr_pc     = 1'b0;
      cmd.wr_last   = (ns_r != '0);
      cmd.wr_conf   = (ns_r != '0);
      cmd.wr_stride = (ns_r != '0) && (conf_r <= pst_pkg::CONF_NEW);
      cmd.conf      = nc;
    end else begin
      cmd.wr_pc     = 1'b1;
      cmd.wr_last   = 1'b1;
      cmd.wr_conf   = 1'b1;
      cmd.wr_stride = 1'b0;
      cmd.conf      = pst_pkg::CONF_NEW;
    end
  end

  // A prefetch must be nonzero and stay in the page of the access.
  assign pn = addr_r + prod_near_r;
  assign pf = addr_r + prod_far_r;
  assign keep_n = (pn != '0) && (((pn ^ addr_r) >> shift_r) == '0);
  assign keep_f = (pf != '0) && (((pf ^ addr_r) >> shift_r) == '0);

  logic          out_valid_r, near_v_r, far_v_r;
  logic [AW-1:0] near_a_r, far_a_r;
  logic          fire_n, fire_f;

  assign fire_n = core_ok && hit_found_r && trig_r && keep_n;
  assign fire_f = core_ok && hit_found_r && trig_r && keep_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      near_v_r <= fire_n;
      far_v_r  <= fire_f;
      near_a_r <= fire_n ? pn : '0;
      far_a_r  <= fire_f ? pf : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_near_valid = near_v_r;
  assign out_near_addr  = near_a_r;
  assign out_far_valid  = far_v_r;
  assign out_far_addr   = far_a_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_UPD;
      ST_UPD:  if (go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result appeared without an update step");

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && hit_found_r && core_ok) |-> (hs.conf != '0))
    else $error("hit entry lost its confidence before selection");

  a_near_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && near_v_r) |-> (near_a_r != '0))
    else $error("near prefetch issued at address zero");
`endif

endmodule
